// ----- rtl/aipr_pkg.sv -----
`default_nettype none
package aipr_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_VALUE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_VALUE = 8'd1;

   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_HEX   = 3'd1,
      ST_BAD_DEC   = 3'd2,
      ST_RANGE     = 3'd3,
      ST_BAD_START = 3'd4,
      ST_NO_DIGITS = 3'd5
   } status_type;

   // parse state handed to the finish stage at the end of a value
   typedef struct packed {
      logic [63:0] acc;
      logic        minus;
      logic        digit;
      logic        hex;
      status_type  err;
   } rec_type;

   function automatic logic [4:0] dec_digit(input logic [7:0] c);
      logic [7:0] d;
      d = c - 8'h30;
      if (c inside {[8'h30:8'h39]}) begin
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] up;
      lo = c - 8'h57;
      up = c - 8'h37;
      if (c inside {[8'h30:8'h39]}) begin
         return dec_digit(c);
      end else if (c inside {[8'h61:8'h66]}) begin
         return {1'b1, lo[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         return {1'b1, up[3:0]};
      end
      return 5'd0;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ascii_integer_parse_range_check.sv -----
`default_nettype none
// Channel  Dir  Handshake          Word
// req      in   req_valid/stall    ch, first, last, empty_req
// rsp      out  rsp_valid/stall    magnitude, is_negative, status, minus_zero_fixed
// csr      in   csr_valid/ready    index, data (min_value, max_value)
//
// One character per cycle while req_stall is low. A result leaves after its last or
// empty word through the parse register, then the range check stage.
// reset clears parse state, pipeline valids and restores the bounds.
// req_stall rises only while a finished value waits behind a stalled rsp.
module ascii_integer_parse_range_check (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [7:0]                          req_ch,
   input  wire logic                                req_first,
   input  wire logic                                req_last,
   input  wire logic                                req_empty_req,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [63:0]                         rsp_magnitude,
   output      logic                                rsp_is_negative,
   output      logic [2:0]                          rsp_status,
   output      logic                                rsp_minus_zero_fixed,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [aipr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [63:0]                         csr_data
);
   import aipr_pkg::*;

   logic        accept, done, out_load;
   rec_type     rec_in, rec_ff;
   logic        rec_valid_ff, rec_valid_in;
   logic [63:0] min_ff, max_ff, negmin_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in, mzf_ff, mzf_in;
   status_type  st_ff, st_in;
   logic        min_pos, fail;

   assign csr_ready = 1'b1;
   assign done      = req_last || req_empty_req;
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = rec_valid_ff && !out_load;
   assign accept    = req_valid && !req_stall;

   aipr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .ch        (req_ch),
      .first     (req_first),
      .last      (req_last),
      .empty_req (req_empty_req),
      .rec       (rec_in)
   );

   assign rec_valid_in = (accept && done) || (rec_valid_ff && !out_load);
   assign rsp_valid_in = out_load ? rec_valid_ff : rsp_valid_ff;

   always_comb begin
      min_pos = !min_ff[63] && (min_ff != 64'd0);
      fail    = 1'b0;
      st_in   = rec_ff.err;
      if (rec_ff.err == ST_OK) begin
         if (!rec_ff.digit) begin
            if (!rec_ff.hex) begin
               st_in = ST_NO_DIGITS;
            end
         end else if (!rec_ff.minus) begin
            fail = (min_pos && (rec_ff.acc < min_ff)) || (rec_ff.acc > max_ff);
         end else begin
            fail = (rec_ff.acc > SIGN_BIT) ||
                   (min_ff[63] ? (rec_ff.acc > negmin_ff)
                               : ((min_ff != 64'd0) || (rec_ff.acc != 64'd0)));
         end
         if (fail) begin
            st_in = ST_RANGE;
         end
      end
      mag_in = (st_in == ST_OK) ? rec_ff.acc : 64'd0;
      neg_in = (st_in == ST_OK) && rec_ff.minus && (rec_ff.acc != 64'd0);
      mzf_in = (st_in == ST_OK) && rec_ff.minus && (rec_ff.acc == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= SIGN_BIT;
         negmin_ff    <= SIGN_BIT;
         max_ff       <= '1;
      end else begin
         rec_valid_ff <= rec_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MIN_VALUE: begin
                  min_ff    <= csr_data;
                  negmin_ff <= 64'd0 - csr_data;
               end
               REG_MAX_VALUE: begin
                  max_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         rec_ff <= rec_in;
      end
      if (out_load && rec_valid_ff) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         mzf_ff <= mzf_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_magnitude        = mag_ff;
   assign rsp_is_negative      = neg_ff;
   assign rsp_status           = st_ff;
   assign rsp_minus_zero_fixed = mzf_ff;

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      rec_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("finished value overrun while rsp stalled");

   a_done_captured: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> rec_valid_ff)
      else $error("finished value not captured");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_magnitude == 64'd0) && !rsp_is_negative && !rsp_minus_zero_fixed)
      else $error("error word carries a value");

   a_sign_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_negative && rsp_minus_zero_fixed))
      else $error("negative and minus zero flags both set");

endmodule
`default_nettype wire

// ----- rtl/aipr_parse.sv -----
`default_nettype none
module aipr_parse (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      ch,
   input  wire logic            first,
   input  wire logic            last,
   input  wire logic            empty_req,
   output aipr_pkg::rec_type    rec
);
   import aipr_pkg::*;

   typedef enum logic [1:0] {
      MODE_UNDECIDED = 2'd0,
      MODE_DEC       = 2'd1,
      MODE_HEX       = 2'd2
   } mode_type;

   logic [7:0]  held_ff, held_in, held_cur;
   logic [1:0]  idx_ff, idx_in, idx_cur;
   mode_type    mode_ff, mode_in, mode_cur;
   logic [63:0] acc_ff, acc_in, acc_cur;
   logic        minus_ff, minus_in, minus_cur;
   logic        digit_ff, digit_in, digit_cur;
   status_type  err_ff, err_in, err_cur;

   logic [4:0]  dec_c, hex_c, dec_h, dig;
   logic [67:0] prod;
   logic [6:0]  pair;

   always_comb begin
      held_cur  = first ? 8'd0 : held_ff;
      idx_cur   = first ? 2'd0 : idx_ff;
      mode_cur  = first ? MODE_UNDECIDED : mode_ff;
      acc_cur   = first ? 64'd0 : acc_ff;
      minus_cur = first ? 1'b0 : minus_ff;
      digit_cur = first ? 1'b0 : digit_ff;
      err_cur   = first ? ST_OK : err_ff;

      dec_c = dec_digit(ch);
      hex_c = hex_digit(ch);
      dec_h = dec_digit(held_cur);
      dig   = (mode_cur == MODE_HEX) ? hex_c : dec_c;
      if (mode_cur == MODE_HEX) begin
         prod = ({4'd0, acc_cur} << 4) + {64'd0, dig[3:0]};
      end else begin
         prod = ({4'd0, acc_cur} << 3) + ({4'd0, acc_cur} << 1) + {64'd0, dig[3:0]};
      end
      pair = ({3'd0, dec_h[3:0]} << 3) + ({3'd0, dec_h[3:0]} << 1) + {3'd0, dec_c[3:0]};

      held_in  = held_cur;
      mode_in  = mode_cur;
      acc_in   = acc_cur;
      minus_in = minus_cur;
      digit_in = digit_cur;
      err_in   = err_cur;
      idx_in   = (idx_cur == 2'd2) ? idx_cur : idx_cur + 2'd1;

      if (err_cur == ST_OK) begin
         case (idx_cur)
            2'd0: begin
               held_in = ch;
               if (last) begin
                  if (ch == 8'h2d) begin
                     minus_in = 1'b1;
                     mode_in  = MODE_DEC;
                  end else if (dec_c[4]) begin
                     mode_in  = MODE_DEC;
                     digit_in = 1'b1;
                     acc_in   = {60'd0, dec_c[3:0]};
                  end else begin
                     err_in = ST_BAD_START;
                  end
               end
            end
            2'd1: begin
               if (ch == 8'h78 || ch == 8'h58) begin
                  mode_in = MODE_HEX;
               end else if (held_cur == 8'h2d) begin
                  minus_in = 1'b1;
                  mode_in  = MODE_DEC;
                  if (dec_c[4]) begin
                     digit_in = 1'b1;
                     acc_in   = {60'd0, dec_c[3:0]};
                  end else begin
                     err_in = ST_BAD_DEC;
                  end
               end else if (dec_h[4]) begin
                  mode_in  = MODE_DEC;
                  digit_in = 1'b1;
                  if (dec_c[4]) begin
                     acc_in = {57'd0, pair};
                  end else begin
                     acc_in = {60'd0, dec_h[3:0]};
                     err_in = ST_BAD_DEC;
                  end
               end else begin
                  err_in = ST_BAD_START;
               end
            end
            default: begin
               if (!dig[4]) begin
                  err_in = (mode_cur == MODE_HEX) ? ST_BAD_HEX : ST_BAD_DEC;
               end else begin
                  digit_in = 1'b1;
                  if (prod[67:64] != 4'd0) begin
                     err_in = ST_RANGE;
                  end else begin
                     acc_in = prod[63:0];
                  end
               end
            end
         endcase
      end

      if (empty_req) begin
         rec = '{acc: 64'd0, minus: 1'b0, digit: 1'b0, hex: 1'b0, err: ST_BAD_START};
      end else begin
         rec = '{acc: acc_in, minus: minus_in, digit: digit_in,
                 hex: (mode_in == MODE_HEX), err: err_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && (last || empty_req))) begin
         held_ff  <= 8'd0;
         idx_ff   <= 2'd0;
         mode_ff  <= MODE_UNDECIDED;
         acc_ff   <= 64'd0;
         minus_ff <= 1'b0;
         digit_ff <= 1'b0;
         err_ff   <= ST_OK;
      end else if (step) begin
         held_ff  <= held_in;
         idx_ff   <= idx_in;
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         minus_ff <= minus_in;
         digit_ff <= digit_in;
         err_ff   <= err_in;
      end
   end

endmodule
`default_nettype wire

// ----- sim/ascii_integer_parse_range_check_tb.sv -----
`timescale 1ns / 1ps

module ascii_integer_parse_range_check_tb;
   import aipr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [63:0] ALL_ONES = '1;

   typedef enum logic [1:0] {
      MODE_UNDECIDED = 2'd0,
      MODE_DEC       = 2'd1,
      MODE_HEX       = 2'd2
   } text_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       first_mark;
      logic       last_mark;
      logic       empty_req;
   } req_word_type;

   typedef struct packed {
      logic [63:0] magnitude;
      logic        is_negative;
      status_type  status;
      logic        minus_zero_fixed;
   } value_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'd0;
   logic        req_first = 1'b0;
   logic        req_last = 1'b0;
   logic        req_empty_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_magnitude;
   logic        rsp_is_negative;
   logic [2:0]  rsp_status;
   logic        rsp_minus_zero_fixed;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [63:0] csr_data = 64'd0;

   ascii_integer_parse_range_check i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ch               (req_ch),
      .req_first            (req_first),
      .req_last             (req_last),
      .req_empty_req        (req_empty_req),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_magnitude        (rsp_magnitude),
      .rsp_is_negative      (rsp_is_negative),
      .rsp_status           (rsp_status),
      .rsp_minus_zero_fixed (rsp_minus_zero_fixed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   req_word_type     pending_words[$];
   value_result_type expected_values[$];
   logic [7:0]       text_buf[$];

   // bounds as last written, and the parse state of the text in progress
   logic [63:0]   cfg_min = SIGN_BIT;
   logic [63:0]   cfg_max = ALL_ONES;
   logic [7:0]    txt_held = 8'd0;
   logic [1:0]    txt_idx = 2'd0;
   text_mode_type txt_mode = MODE_UNDECIDED;
   logic [63:0]   txt_acc = 64'd0;
   logic          txt_minus = 1'b0;
   logic          txt_digit = 1'b0;
   status_type    txt_err = ST_OK;

   int words_pushed = 0;
   int words_accepted = 0;
   int values_checked = 0;
   int mismatch_count = 0;
   int settings_used = 1;
   int status_tally[0:7] = '{default: 0};

   req_word_type     offered_word;
   value_result_type got_value;
   int  burst_left = 0;
   int  gap_left = 0;
   int  stall_run = 0;
   bit  stall_on = 1'b0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;
   int  cycle_count = 0;

   function automatic void clear_text();
      txt_held = 8'd0;
      txt_idx = 2'd0;
      txt_mode = MODE_UNDECIDED;
      txt_acc = 64'd0;
      txt_minus = 1'b0;
      txt_digit = 1'b0;
      txt_err = ST_OK;
   endfunction

   function automatic void note_error(input status_type code);
      if (txt_err == ST_OK) begin
         txt_err = code;
      end
   endfunction

   function automatic void add_digit(input logic [63:0] base, input logic [63:0] digit);
      txt_digit = 1'b1;
      if (txt_acc > ALL_ONES / base) begin
         note_error(ST_RANGE);
      end else begin
         txt_acc = txt_acc * base;
         if (txt_acc > ALL_ONES - digit) begin
            note_error(ST_RANGE);
         end else begin
            txt_acc = txt_acc + digit;
         end
      end
   endfunction

   function automatic void dec_char(input logic [7:0] c);
      if (c < "0" || c > "9") begin
         note_error(ST_BAD_DEC);
      end else begin
         add_digit(64'd10, 64'(c - "0"));
      end
   endfunction

   function automatic void hex_char(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         add_digit(64'd16, 64'(c - "0"));
      end else if (c >= "a" && c <= "f") begin
         add_digit(64'd16, 64'(c - "a") + 64'd10);
      end else if (c >= "A" && c <= "F") begin
         add_digit(64'd16, 64'(c - "A") + 64'd10);
      end else begin
         note_error(ST_BAD_HEX);
      end
   endfunction

   function automatic void decide_decimal();
      if (txt_held == "-") begin
         txt_minus = 1'b1;
         txt_mode = MODE_DEC;
      end else if (txt_held >= "0" && txt_held <= "9") begin
         txt_mode = MODE_DEC;
         dec_char(txt_held);
      end else begin
         note_error(ST_BAD_START);
      end
   endfunction

   function automatic value_result_type close_value();
      value_result_type r;
      r.magnitude = 64'd0;
      r.is_negative = 1'b0;
      r.minus_zero_fixed = 1'b0;
      r.status = txt_err;
      if (txt_err == ST_OK) begin
         if (txt_mode == MODE_HEX && !txt_digit) begin
            r.status = ST_OK;
         end else if (!txt_digit) begin
            r.status = ST_NO_DIGITS;
         end else if (!txt_minus) begin
            if (($signed(cfg_min) > 0 && txt_acc < cfg_min) || txt_acc > cfg_max) begin
               r.status = ST_RANGE;
            end
         end else if (txt_acc > SIGN_BIT || $signed(64'd0 - txt_acc) < $signed(cfg_min)) begin
            r.status = ST_RANGE;
         end
         if (r.status == ST_OK) begin
            r.magnitude = txt_acc;
            r.is_negative = txt_minus;
            if (txt_minus && txt_acc == 64'd0) begin
               r.is_negative = 1'b0;
               r.minus_zero_fixed = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic void parse_word(input req_word_type w);
      value_result_type r;
      if (w.empty_req) begin
         r.magnitude = 64'd0;
         r.is_negative = 1'b0;
         r.status = ST_BAD_START;
         r.minus_zero_fixed = 1'b0;
         expected_values.push_back(r);
         status_tally[int'(r.status)]++;
         clear_text();
         return;
      end
      if (w.first_mark) begin
         clear_text();
      end
      if (txt_err == ST_OK) begin
         if (txt_idx == 2'd0) begin
            txt_held = w.ch;
            if (w.last_mark) begin
               decide_decimal();
            end
         end else if (txt_idx == 2'd1) begin
            if (w.ch == "x" || w.ch == "X") begin
               txt_mode = MODE_HEX;
            end else begin
               decide_decimal();
               if (txt_err == ST_OK) begin
                  dec_char(w.ch);
               end
            end
         end else if (txt_mode == MODE_HEX) begin
            hex_char(w.ch);
         end else begin
            dec_char(w.ch);
         end
      end
      if (txt_idx < 2'd2) begin
         txt_idx++;
      end
      if (w.last_mark) begin
         r = close_value();
         expected_values.push_back(r);
         status_tally[int'(r.status)]++;
         clear_text();
      end
   endfunction

   // sender: bursts of random length, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_word(offered_word);
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || pending_words.size() == 0) begin
               if (gap_left != 0) begin
                  gap_left--;
               end
               req_valid <= 1'b0;
            end else begin
               offered_word = pending_words.pop_front();
               req_ch <= offered_word.ch;
               req_first <= offered_word.first_mark;
               req_last <= offered_word.last_mark;
               req_empty_req <= offered_word.empty_req;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // receiver: check results, stall on runs of random length, one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected word: magnitude %h status %0d", $time,
                        rsp_magnitude, rsp_status);
               mismatch_count++;
            end else begin
               got_value = expected_values.pop_front();
               values_checked++;
               if (rsp_magnitude !== got_value.magnitude) begin
                  $display("%0t: magnitude expected %h actual %h", $time,
                           got_value.magnitude, rsp_magnitude);
                  mismatch_count++;
               end
               if (rsp_is_negative !== got_value.is_negative) begin
                  $display("%0t: is_negative expected %b actual %b", $time,
                           got_value.is_negative, rsp_is_negative);
                  mismatch_count++;
               end
               if (rsp_status !== got_value.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           got_value.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_minus_zero_fixed !== got_value.minus_zero_fixed) begin
                  $display("%0t: minus_zero_fixed expected %b actual %b", $time,
                           got_value.minus_zero_fixed, rsp_minus_zero_fixed);
                  mismatch_count++;
               end
            end
         end
         if (!long_hold_done && values_checked >= 30) begin
            long_hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_run == 0) begin
               stall_on = ($urandom_range(0, 2) == 0);
               stall_run = stall_on ? $urandom_range(1, 20) : $urandom_range(1, 30);
            end
            stall_run--;
            rsp_stall <= stall_on;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d values outstanding", cycle_count,
                  expected_values.size());
         $display("ascii_integer_parse_range_check_tb: FAIL");
         $finish;
      end
   end

   task automatic push_word(input logic [7:0] c, input logic f, input logic l,
                            input logic e);
      req_word_type w;
      w.ch = c;
      w.first_mark = f;
      w.last_mark = l;
      w.empty_req = e;
      pending_words.push_back(w);
      words_pushed++;
   endtask

   task automatic send_text(input bit mark_first, input bit mark_last);
      int n;
      n = text_buf.size();
      for (int i = 0; i < n; i++) begin
         push_word(text_buf[i], mark_first && i == 0, mark_last && i == n - 1, 1'b0);
      end
   endtask

   task automatic send_string(input string s, input bit mark_first, input bit mark_last);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
      send_text(mark_first, mark_last);
   endtask

   task automatic pick_value(output logic [63:0] mag, output logic minus);
      logic [63:0] jitter;
      jitter = $urandom_range(0, 4);
      minus = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 7))
         0: mag = $urandom_range(0, 20);
         1: mag = $urandom_range(0, 99999);
         2: mag = $urandom;
         3: mag = {$urandom, $urandom};
         4: mag = SIGN_BIT + jitter - 64'd2;
         5: mag = ALL_ONES - jitter;
         6: begin
            mag = cfg_max + jitter - 64'd2;
            minus = 1'b0;
         end
         default: begin
            if ($signed(cfg_min) < 0) begin
               mag = 64'd0 - cfg_min + jitter - 64'd2;
               minus = 1'b1;
            end else begin
               mag = cfg_min + jitter - 64'd2;
               minus = 1'b0;
            end
         end
      endcase
   endtask

   task automatic load_decimal();
      logic [63:0] v;
      logic        minus;
      pick_value(v, minus);
      text_buf.delete();
      do begin
         text_buf.push_front(8'(64'h30 + v % 64'd10));
         v = v / 64'd10;
      end while (v != 64'd0);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) text_buf.push_front("0");
      end
      if ($urandom_range(0, 7) == 0) begin
         text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
      end
      if (minus) begin
         text_buf.push_front("-");
      end
   endtask

   task automatic load_hex();
      int          d;
      logic [7:0]  letter_base;
      text_buf.delete();
      text_buf.push_back(8'($urandom_range(0, 255)));
      text_buf.push_back($urandom_range(0, 1) ? "x" : "X");
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(15, 17) : $urandom_range(0, 8)) begin
         d = $urandom_range(0, 15);
         letter_base = $urandom_range(0, 1) ? "a" : "A";
         text_buf.push_back(d < 10 ? 8'(8'h30 + d) : 8'(letter_base + d - 10));
      end
   endtask

   task automatic random_text();
      int k;
      k = $urandom_range(0, 19);
      if (k == 17) begin
         push_word(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom), 1'b1);
         return;
      end
      if (k < 9) begin
         load_decimal();
      end else if (k < 13) begin
         load_hex();
      end else if (k < 15) begin
         text_buf.delete();
         repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else if (k < 17) begin
         if ($urandom_range(0, 1)) begin
            load_decimal();
         end else begin
            load_hex();
         end
         text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (k == 18) begin
         // fragment, then a continuation, a restart or an abandon
         load_decimal();
         send_text(1'b1, 1'b0);
         case ($urandom_range(0, 2))
            0: begin
               load_decimal();
               send_text(1'b0, 1'b1);
            end
            1: begin
               load_hex();
               send_text(1'b1, 1'b1);
            end
            default: push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
         endcase
         return;
      end else begin
         load_decimal();
         send_text(1'b0, 1'b1);
         return;
      end
      send_text(1'b1, 1'b1);
   endtask

   task automatic run_random(input int n);
      int target;
      target = words_pushed + n;
      while (words_pushed < target) begin
         random_text();
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (words_accepted != words_pushed || expected_values.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MIN_VALUE) begin
         cfg_min = data;
      end else begin
         cfg_max = data;
      end
   endtask

   task automatic set_bounds(input logic [63:0] lo, input logic [63:0] hi);
      wait_idle();
      write_reg(REG_MIN_VALUE, lo);
      write_reg(REG_MAX_VALUE, hi);
      settings_used++;
      run_random(105);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_word(8'h41, 1'b1, 1'b1, 1'b1);
      send_string("0", 1'b1, 1'b1);
      send_string("-", 1'b1, 1'b1);
      send_string("-0", 1'b1, 1'b1);
      send_string("a", 1'b1, 1'b1);
      send_string("ab", 1'b1, 1'b1);
      send_string("0x", 1'b1, 1'b1);
      send_string("-x1", 1'b1, 1'b1);
      send_string("0xg1", 1'b1, 1'b1);
      send_string("12a9", 1'b1, 1'b1);
      send_string("--5", 1'b1, 1'b1);
      send_string("18446744073709551615", 1'b1, 1'b1);
      send_string("18446744073709551616", 1'b1, 1'b1);
      send_string("-9223372036854775808", 1'b1, 1'b1);
      send_string("-9223372036854775809", 1'b1, 1'b1);
      send_string("0xFFFFFFFFFFFFFFFF", 1'b1, 1'b1);
      send_string("0x10000000000000000", 1'b1, 1'b1);
      send_string("zXaBcDeF", 1'b1, 1'b1);
      push_word(8'h00, 1'b1, 1'b1, 1'b0);
      push_word(8'hFF, 1'b1, 1'b0, 1'b0);
      push_word(8'h30, 1'b0, 1'b1, 1'b0);
      send_string("12", 1'b1, 1'b0);
      send_string("3", 1'b0, 1'b1);
      send_string("45", 1'b1, 1'b0);
      push_word(8'hFF, 1'b0, 1'b1, 1'b1);
      send_string("9", 1'b0, 1'b1);
      run_random(105);

      set_bounds(SIGN_BIT, ALL_ONES);
      set_bounds(64'd0, 64'd1000);
      set_bounds(64'd100, 64'd5000);
      set_bounds(64'hFFFF_FFFF_FFFF_FC18, SIGN_BIT);
      set_bounds(64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES);
      set_bounds(ALL_ONES, 64'd0);
      set_bounds({$urandom, $urandom}, {$urandom, $urandom});
      wait_idle();

      $display("%0d words sent, %0d values checked under %0d bound settings",
               words_accepted, values_checked, settings_used);
      $display("status ok %0d, bad hex %0d, bad dec %0d, range %0d, bad start %0d, no digits %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4], status_tally[5]);
      if (mismatch_count == 0) begin
         $display("ascii_integer_parse_range_check_tb: PASS");
      end else begin
         $display("ascii_integer_parse_range_check_tb: FAIL");
      end
      $finish;
   end

endmodule
